### rtl/mbps_pkg.sv
`default_nettype none

package mbps_pkg;

    localparam int PATTERN_MAX_DEF  = 16;
    localparam int ADDRESS_BITS_DEF = 48;

    localparam int PAT_BYTES   = 16;
    localparam int LEN_W       = 5;
    localparam int OUT_ADDR_W  = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO   = 3'd0,
        CFG_PAT_HI   = 3'd1,
        CFG_CARE     = 3'd2,
        CFG_LEN      = 3'd3,
        CFG_BASE     = 3'd4
    } cfg_index_t;

    typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_t;
    typedef logic [PAT_BYTES-1:0]      care_mask_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } win_ctrl_t;

    typedef struct packed {
        logic                  found;
        logic [OUT_ADDR_W-1:0] addr;
    } result_t;

    // Masked compare of one byte against pattern byte k; bytes past the
    // stored pattern are wildcards.
    function automatic logic byte_ok(
        input logic [7:0]       b,
        input logic [LEN_W-1:0] k,
        input pat_bytes_t       pat,
        input care_mask_t       care
    );
        logic ok;
        ok = 1'b1;
        if (k < LEN_W'(PAT_BYTES)) begin
            ok = !care[k[3:0]] || (b == pat[k[3:0]]);
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

### rtl/mbps_cell.sv
`default_nettype none

module mbps_cell import mbps_pkg::*; #(
    parameter int IDX = 0
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire win_ctrl_t        ctrl,
    input  wire logic [7:0]       din,
    input  wire logic [LEN_W-1:0] len,
    input  wire pat_bytes_t       pat,
    input  wire care_mask_t       care,
    output logic [7:0]            dout,
    output logic                  ok
);

    localparam logic [LEN_W:0] OFS = (LEN_W+1)'(IDX + 2);

    logic [7:0]       win_reg;
    logic [LEN_W:0]   k_full;
    logic [LEN_W-1:0] k;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            win_reg <= '0;
        end else if (ctrl.shift) begin
            win_reg <= din;
        end
    end

    assign k_full = {1'b0, len} - OFS;
    assign k      = k_full[LEN_W-1:0];

    always_comb begin
        ok = 1'b1;
        if ({1'b0, len} >= OFS) begin
            ok = byte_ok(win_reg, k, pat, care);
        end
    end

    assign dout = win_reg;

endmodule

`default_nettype wire

### rtl/mbps_obuf.sv
`default_nettype none

module mbps_obuf import mbps_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;
    logic    pop;

    assign pop = out_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= push;
            end else begin
                out_valid_reg  <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
                if (push) begin
                    skid_reg <= push_data;
                end
            end else if (push) begin
                out_reg <= push_data;
            end
        end else if (push) begin
            skid_reg <= push_data;
        end
    end

    assign ready     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

### rtl/masked_byte_pattern_search.sv
// Output: the result for a byte is registered in the output buffer before it is offered on m_tvalid.
// Throughput: one byte per cycle while the output buffer is not full; the head compare and
// the row of window cells check all pattern positions in the same cycle the byte arrives,
// and a two-entry output buffer keeps s_tready high while one result waits.
// Reset: synchronous, active low; clears the window, scan state, output buffer and
// all configuration registers.
`default_nettype none

module masked_byte_pattern_search import mbps_pkg::*; #(
    parameter int PATTERN_MAX  = PATTERN_MAX_DEF,
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] data_byte
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_ADDR_W-1:0]      m_tdata,   // [47:0] match_address
    output logic                       m_tuser,   // [0] found
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CELLS = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;

    logic [63:0]             pat_lo_reg;
    logic [63:0]             pat_hi_reg;
    care_mask_t              care_reg;
    logic [LEN_W-1:0]        len_reg;
    logic [OUT_ADDR_W-1:0]   base_reg;

    logic [ADDRESS_BITS-1:0] count_reg;
    logic [ADDRESS_BITS-1:0] count_next;
    logic                    finished_reg;

    pat_bytes_t              pat;
    win_ctrl_t               ctrl;
    logic [CELLS:0][7:0]     chain;
    logic [CELLS-1:0]        cell_ok;
    logic                    head_ok;
    logic                    len_ok;
    logic                    hit;
    logic                    accept;
    logic                    push;
    result_t                 res;
    result_t                 m_res;
    logic [63:0]             base_w;
    logic [ADDRESS_BITS-1:0] addr_sum;
    logic [63:0]             addr_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            care_reg   <= '0;
            len_reg    <= '0;
            base_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PAT_LO: pat_lo_reg <= cfg_wdata;
                CFG_PAT_HI: pat_hi_reg <= cfg_wdata;
                CFG_CARE:   care_reg   <= cfg_wdata[PAT_BYTES-1:0];
                CFG_LEN:    len_reg    <= cfg_wdata[LEN_W-1:0];
                CFG_BASE:   base_reg   <= cfg_wdata[OUT_ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    assign pat = {pat_hi_reg, pat_lo_reg};

    assign accept = s_tvalid && s_tready;

    assign count_next = (count_reg == '1) ? count_reg : count_reg + ADDRESS_BITS'(1);

    assign head_ok = (len_reg != '0) &&
                     byte_ok(s_tdata, len_reg - LEN_W'(1), pat, care_reg);
    assign len_ok  = (len_reg != '0) &&
                     ({1'b0, len_reg} <= (LEN_W+1)'(PATTERN_MAX)) &&
                     (count_next >= ADDRESS_BITS'(len_reg));
    assign hit     = len_ok && head_ok && (&cell_ok);

    assign ctrl.clear = accept && s_tlast;
    assign ctrl.shift = accept && !finished_reg && !hit && !s_tlast;

    assign chain[0] = s_tdata;

    for (genvar j = 0; j < CELLS; j++) begin : g_cell
        mbps_cell #(
            .IDX (j)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .din     (chain[j]),
            .len     (len_reg),
            .pat     (pat),
            .care    (care_reg),
            .dout    (chain[j+1]),
            .ok      (cell_ok[j])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            count_reg    <= '0;
            finished_reg <= 1'b0;
        end else if (accept && !finished_reg) begin
            if (hit) begin
                finished_reg <= 1'b1;
            end else begin
                count_reg <= count_next;
            end
        end
    end

    assign base_w   = 64'(base_reg);
    assign addr_sum = base_w[ADDRESS_BITS-1:0] + count_next - ADDRESS_BITS'(len_reg);
    assign addr_w   = 64'(addr_sum);

    assign push      = accept && !finished_reg && (hit || s_tlast);
    assign res.found = hit;
    assign res.addr  = hit ? addr_w[OUT_ADDR_W-1:0] : '0;

    mbps_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (res),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_res)
    );

    assign m_tdata = m_res.addr;
    assign m_tuser = m_res.found;

endmodule

`default_nettype wire

### rtl/mbps_checker.sv
`default_nettype none

module mbps_checker import mbps_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_ADDR_W-1:0] m_tdata,
    input wire logic                  m_tuser
);

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result dropped or changed while stalled");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("no-match result carries nonzero address");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
